### rtl/pqie_pkg.sv
package pqie_pkg;

  // Fixed-point format: unsigned values with FRAC fractional bits
  localparam int FRAC = 30;

  localparam int LUMA_W = 24;
  localparam int CODE_W = 16;

  localparam int LUMA_FRAC_BITS_DEF = 10;
  localparam int CODE_BITS_DEF      = 16;

  // ln(2) in Q.30
  localparam logic [FRAC-1:0] LN2_Q = 30'd744261118;

  // log2 result: 5 integer bits and FRAC fractional bits
  localparam int LOG_W = 35;
  // exp2 result: 0 .. 1.0 inclusive
  localparam int EXP_W = FRAC + 1;
  // exponent widths feeding the two exp2 units
  localparam int E1_W  = 33;
  localparam int E2_W  = 42;
  // scaled numerator and denominator of the rational term
  localparam int NUM_W = 42;
  // series terms of exp2 and divisor width
  localparam int NTERMS = 24;
  localparam int DV_W   = 5;

  // ST 2084 constants
  localparam int M1_N  = 2610;   // m1 * 16384
  localparam int M2_N  = 2523;   // m2 * 32
  localparam int C1_N  = 107;    // c1 * 128
  localparam int C2_N  = 2413;   // c2 * 128
  localparam int C3_N  = 2392;   // c3 * 128
  localparam int C_DEN = 128;

  // Elaboration-time log2 in Q.30, same rounding as the hardware unit
  function automatic logic [63:0] log2_const(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] res;
    int          n;
    n = 0;
    for (int b = 0; b < 64; b++) begin
      if (x[b]) n = b;
    end
    if (n >= FRAC) m = x >> (n - FRAC);
    else m = x << (FRAC - n);
    res = 64'(n) << FRAC;
    for (int i = 1; i <= FRAC; i++) begin
      m = (m * m) >> FRAC;
      if (m >= (64'd2 << FRAC)) begin
        m   = m >> 1;
        res = res | (64'd1 << (FRAC - i));
      end
    end
    return res;
  endfunction

endpackage

### rtl/pq_inverse_eotf_encoder_unit.sv
// PQ (ST 2084) inverse EOTF encoder.
// Input channel: in_valid_i / in_ready_o with luminance_i, an absolute luminance
// with LUMA_FRAC_BITS fractional bits of one nit. Output channel: out_valid_o /
// out_ready_i with pq_code_o, the PQ code scaled to 2^CODE_BITS - 1.
// One result per input, in input order. Luminance at or above 10000 nit gives
// the full-scale code; zero gives the c1^m2 code.
// The chain from accepted input to valid output is
// input register (1), log2 (31), exponent scale (1), exp2 (74), rational
// setup (1), divider (30), log2 (31), exponent scale (1), exp2 (74), code
// rounding (1). The log2 units take one squaring per stage, exp2 one series
// term per three stages, the divider one quotient bit per stage.
// Throughput: one transaction per cycle while the receiver takes results.
// A stall on out_ready_i freezes the whole pipeline and drops in_ready_o;
// nothing is lost or repeated. The output register holds its transaction
// until taken.
// Reset clears all valid bits; the datapath registers are not reset.
module pq_inverse_eotf_encoder_unit #(
  parameter int LUMA_FRAC_BITS = pqie_pkg::LUMA_FRAC_BITS_DEF,
  parameter int CODE_BITS      = pqie_pkg::CODE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pqie_pkg::LUMA_W-1:0] luminance_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pqie_pkg::CODE_W-1:0] pq_code_o
);
  import pqie_pkg::*;

  localparam int PK_W = 48;
  localparam logic [PK_W-1:0]   PEAK     = PK_W'(10000) << LUMA_FRAC_BITS;
  localparam logic [LOG_W-1:0]  LOG_TOP  =
    LOG_W'(log2_const(64'd10000) + (64'(LUMA_FRAC_BITS) << FRAC));
  localparam logic [LOG_W-1:0]  LOG_FULL = LOG_W'(FRAC) << FRAC;
  localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'((1 << CODE_BITS) - 1);
  localparam logic [EXP_W-1:0]  ONE_Q    = EXP_W'(1) << FRAC;
  localparam int ML_W = 48;
  localparam int CP_W = EXP_W + CODE_W;

  logic en;

  // input register
  logic              p0_vld_q;
  logic [LUMA_W-1:0] p0_lum_q;
  logic              p0_sat_q;
  logic              p0_zero_q;

  // first log2
  logic             la_vld;
  logic [LOG_W-1:0] la_log;
  logic [1:0]       la_side;

  // exponent for Ym
  logic             p1_vld_q;
  logic [E1_W-1:0]  p1_e_q;
  logic [1:0]       p1_side_q;
  logic [LOG_W-1:0] d1;
  logic [ML_W-1:0]  e1_wide;

  // Ym
  logic             ea_vld;
  logic [EXP_W-1:0] ea_y;
  logic [1:0]       ea_side;

  // rational setup
  logic             p2_vld_q;
  logic [NUM_W-1:0] p2_num_q;
  logic [NUM_W-1:0] p2_den_q;
  logic [1:0]       p2_side_q;
  logic [EXP_W-1:0] ym;

  // divider
  logic             dv_vld;
  logic [FRAC-1:0]  dv_quo;
  logic [1:0]       dv_side;
  logic [EXP_W-1:0] ratio;

  // second log2
  logic             lb_vld;
  logic [LOG_W-1:0] lb_log;
  logic             lb_sat;

  // exponent for E
  logic             p4_vld_q;
  logic [E2_W-1:0]  p4_e_q;
  logic             p4_sat_q;
  logic [LOG_W-1:0] d2;
  logic [ML_W-1:0]  e2_wide;

  // E
  logic             eb_vld;
  logic [EXP_W-1:0] eb_y;
  logic             eb_sat;

  // output register
  logic              out_vld_q;
  logic [CODE_W-1:0] pq_code_q;
  logic [CP_W-1:0]   code_wide;
  logic [CODE_W:0]   code_rnd;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p0_vld_q  <= in_valid_i;
      p1_vld_q  <= la_vld;
      p2_vld_q  <= ea_vld;
      p4_vld_q  <= lb_vld;
      out_vld_q <= eb_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_lum_q  <= luminance_i;
      p0_sat_q  <= PK_W'(luminance_i) >= PEAK;
      p0_zero_q <= luminance_i == '0;
    end
  end

  pqie_log2 #(
    .X_W    (LUMA_W),
    .SIDE_W (2)
  ) u_log_lum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p0_vld_q),
    .x_i    (p0_lum_q),
    .side_i ({p0_sat_q, p0_zero_q}),
    .vld_o  (la_vld),
    .log_o  (la_log),
    .side_o (la_side)
  );

  // e = -log2(Ym) = m1 * (log2(peak) - log2(lum)), rounded
  always_comb begin
    d1      = (LOG_TOP > la_log) ? LOG_TOP - la_log : '0;
    e1_wide = ML_W'(d1) * ML_W'(M1_N) + ML_W'(8192);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_e_q    <= e1_wide[E1_W+13:14];
      p1_side_q <= la_side;
    end
  end

  pqie_exp2 #(
    .E_W    (E1_W),
    .SIDE_W (2)
  ) u_exp_ym (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p1_vld_q),
    .e_i    (p1_e_q),
    .side_i (p1_side_q),
    .vld_o  (ea_vld),
    .y_o    (ea_y),
    .side_o (ea_side)
  );

  // Numerator reaches the denominator only when Ym is exactly one
  assign ym = ea_side[0] ? '0 : ea_y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_num_q  <= (NUM_W'(C1_N) << FRAC) + NUM_W'(ym) * NUM_W'(C2_N);
      p2_den_q  <= (NUM_W'(C_DEN) << FRAC) + NUM_W'(ym) * NUM_W'(C3_N);
      p2_side_q <= {ea_side[1], ym >= ONE_Q};
    end
  end

  pqie_div #(
    .SIDE_W (2)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p2_vld_q),
    .num_i  (p2_num_q),
    .den_i  (p2_den_q),
    .side_i (p2_side_q),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .side_o (dv_side)
  );

  assign ratio = dv_side[0] ? ONE_Q : EXP_W'(dv_quo);

  pqie_log2 #(
    .X_W    (EXP_W),
    .SIDE_W (1)
  ) u_log_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_vld),
    .x_i    (ratio),
    .side_i (dv_side[1]),
    .vld_o  (lb_vld),
    .log_o  (lb_log),
    .side_o (lb_sat)
  );

  // e2 = -m2 * log2(ratio), rounded
  always_comb begin
    d2      = (LOG_FULL > lb_log) ? LOG_FULL - lb_log : '0;
    e2_wide = ML_W'(d2) * ML_W'(M2_N) + ML_W'(16);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_e_q   <= e2_wide[E2_W+4:5];
      p4_sat_q <= lb_sat;
    end
  end

  pqie_exp2 #(
    .E_W    (E2_W),
    .SIDE_W (1)
  ) u_exp_e (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (p4_vld_q),
    .e_i    (p4_e_q),
    .side_i (p4_sat_q),
    .vld_o  (eb_vld),
    .y_o    (eb_y),
    .side_o (eb_sat)
  );

  always_comb begin
    code_wide = CP_W'(eb_y) * CP_W'(CODE_MAX) + (CP_W'(1) << (FRAC - 1));
    code_rnd  = code_wide[CP_W-1:FRAC];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (eb_sat || code_rnd > (CODE_W + 1)'(CODE_MAX)) pq_code_q <= CODE_MAX;
      else pq_code_q <= code_rnd[CODE_W-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign pq_code_o   = pq_code_q;

  a_sat_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && eb_vld && eb_sat) |=> (out_valid_o && pq_code_o == CODE_MAX))
    else $error("saturated luminance did not give full-scale code");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pq_code_o <= CODE_MAX))
    else $error("code above full scale");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && dv_vld) |=> (dv_vld && $stable(dv_quo) && $stable(dv_side)))
    else $error("divider output moved during stall");

endmodule

### rtl/pqie_log2.sv
module pqie_log2 #(
  parameter int X_W    = 24,
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [X_W-1:0]             x_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       vld_o,
  output logic [pqie_pkg::LOG_W-1:0] log_o,
  output logic [SIDE_W-1:0]          side_o
);
  import pqie_pkg::*;

  localparam int N_W  = $clog2(X_W);
  localparam int M_W  = FRAC + 1;
  localparam int SQ_W = 2 * M_W;
  localparam int WD_W = X_W + FRAC;

  typedef struct packed {
    logic [N_W-1:0]    n;
    logic [FRAC-1:0]   f;
    logic [M_W-1:0]    m;
    logic [SIDE_W-1:0] side;
  } stg_t;

  stg_t          stg_q [FRAC+1];
  logic [FRAC:0] vld_q;

  logic [N_W-1:0]  lead_n;
  logic [WD_W-1:0] wide;
  stg_t            stg0_d;

  // One squaring round: square the mantissa, pull out one result bit
  function automatic stg_t log_step(input stg_t s, input int g);
    logic [SQ_W-1:0] sq;
    stg_t            r;
    r  = s;
    sq = SQ_W'(s.m) * SQ_W'(s.m);
    if (sq[SQ_W-1]) begin
      r.m = sq[SQ_W-1:FRAC+1];
      r.f[FRAC-1-g] = 1'b1;
    end else begin
      r.m = sq[SQ_W-2:FRAC];
    end
    return r;
  endfunction

  // Normalize: integer part is the leading-one position
  always_comb begin
    lead_n = '0;
    for (int b = 0; b < X_W; b++) begin
      if (x_i[b]) lead_n = N_W'(b);
    end
    wide        = WD_W'(x_i) << (FRAC - int'(lead_n));
    stg0_d.n    = lead_n;
    stg0_d.f    = '0;
    stg0_d.m    = wide[M_W-1:0];
    stg0_d.side = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FRAC-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= stg0_d;
      for (int g = 0; g < FRAC; g++) begin
        stg_q[g+1] <= log_step(stg_q[g], g);
      end
    end
  end

  assign vld_o  = vld_q[FRAC];
  assign log_o  = (LOG_W'(stg_q[FRAC].n) << FRAC) | LOG_W'(stg_q[FRAC].f);
  assign side_o = stg_q[FRAC].side;

endmodule

### rtl/pqie_exp2.sv
module pqie_exp2 #(
  parameter int E_W    = 33,
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [E_W-1:0]             e_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       vld_o,
  output logic [pqie_pkg::EXP_W-1:0] y_o,
  output logic [SIDE_W-1:0]          side_o
);
  import pqie_pkg::*;

  localparam int K_W   = E_W - FRAC;
  localparam int SUM_W = 32;
  localparam int T_W   = FRAC + 1;
  localparam int RC_W  = 33;
  localparam int Y_W   = FRAC + RC_W;
  localparam int Q_W   = Y_W - 32;
  localparam int R_W   = Q_W + DV_W;
  localparam int ZP_W  = 2 * FRAC;
  localparam int TP_W  = T_W + FRAC;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [T_W-1:0]    term;
    logic [FRAC-1:0]   z;
    logic [K_W-1:0]    k;
    logic [FRAC-1:0]   x;
    logic [Y_W-1:0]    y;
    logic [SIDE_W-1:0] side;
  } stg_t;

  stg_t t_q [NTERMS+1];
  stg_t a_q [NTERMS];
  stg_t b_q [NTERMS];

  logic [NTERMS:0]   t_vld_q;
  logic [NTERMS-1:0] a_vld_q;
  logic [NTERMS-1:0] b_vld_q;
  logic              o_vld_q;
  logic [EXP_W-1:0]  o_y_q;
  logic [SIDE_W-1:0] o_side_q;

  logic [RC_W-1:0] rcp [NTERMS];
  logic [DV_W-1:0] dvs [NTERMS];

  logic [ZP_W-1:0] zp;
  stg_t            t0_d;

  for (genvar g = 0; g < NTERMS; g++) begin : g_rcp
    localparam int Div = g + 1;
    localparam logic [RC_W-1:0] Rcp = RC_W'((64'd1 << 32) / Div);
    assign rcp[g] = Rcp;
    assign dvs[g] = DV_W'(Div);
  end

  // term * z, drop FRAC bits
  function automatic stg_t mul_step(input stg_t s);
    logic [TP_W-1:0] p;
    stg_t            r;
    r   = s;
    p   = TP_W'(s.term) * TP_W'(s.z);
    r.x = p[2*FRAC-1:FRAC];
    return r;
  endfunction

  // Quotient estimate by reciprocal multiplication
  function automatic stg_t rcp_step(input stg_t s, input logic [RC_W-1:0] rc);
    stg_t r;
    r   = s;
    r.y = Y_W'(s.x) * Y_W'(rc);
    return r;
  endfunction

  // Reciprocal estimate, one correction, then accumulate with alternating sign
  function automatic stg_t div_step(input stg_t s, input logic [DV_W-1:0] dv, input int g);
    logic [Q_W-1:0] q;
    logic [R_W-1:0] rem;
    stg_t           r;
    r   = s;
    q   = s.y[Y_W-1:32];
    rem = R_W'(s.x) - R_W'(q) * R_W'(dv);
    if (rem >= R_W'(dv)) q = q + 1'b1;
    r.term = T_W'(q);
    if ((g % 2) == 0) r.sum = s.sum - SUM_W'(q);
    else r.sum = s.sum + SUM_W'(q);
    return r;
  endfunction

  always_comb begin
    zp        = ZP_W'(e_i[FRAC-1:0]) * ZP_W'(LN2_Q) + (ZP_W'(1) << (FRAC - 1));
    t0_d      = '0;
    t0_d.sum  = SUM_W'(1) << FRAC;
    t0_d.term = T_W'(1) << FRAC;
    t0_d.z    = zp[2*FRAC-1:FRAC];
    t0_d.k    = e_i[E_W-1:FRAC];
    t0_d.side = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= '0;
      a_vld_q <= '0;
      b_vld_q <= '0;
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      t_vld_q[0] <= vld_i;
      for (int g = 0; g < NTERMS; g++) begin
        a_vld_q[g]   <= t_vld_q[g];
        b_vld_q[g]   <= a_vld_q[g];
        t_vld_q[g+1] <= b_vld_q[g];
      end
      o_vld_q <= t_vld_q[NTERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= t0_d;
      for (int g = 0; g < NTERMS; g++) begin
        a_q[g]     <= mul_step(t_q[g]);
        b_q[g]     <= rcp_step(a_q[g], rcp[g]);
        t_q[g+1]   <= div_step(b_q[g], dvs[g], g);
      end
      if (32'(t_q[NTERMS].k) >= 32'd31) o_y_q <= '0;
      else o_y_q <= EXP_W'(t_q[NTERMS].sum >> t_q[NTERMS].k);
      o_side_q <= t_q[NTERMS].side;
    end
  end

  assign vld_o  = o_vld_q;
  assign y_o    = o_y_q;
  assign side_o = o_side_q;

endmodule

### rtl/pqie_div.sv
module pqie_div #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [pqie_pkg::NUM_W-1:0] num_i,
  input  logic [pqie_pkg::NUM_W-1:0] den_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       vld_o,
  output logic [pqie_pkg::FRAC-1:0]  quo_o,
  output logic [SIDE_W-1:0]          side_o
);
  import pqie_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [NUM_W-1:0]  den;
    logic [FRAC-1:0]   q;
    logic [SIDE_W-1:0] side;
  } stg_t;

  stg_t            stg_q [FRAC];
  logic [FRAC-1:0] vld_q;
  stg_t            init_d;

  // One restoring step
  function automatic stg_t div_step(input stg_t s);
    logic [NUM_W:0] sh;
    logic [NUM_W:0] df;
    stg_t           r;
    r  = s;
    sh = {s.rem, 1'b0};
    df = sh - {1'b0, s.den};
    if (sh >= {1'b0, s.den}) begin
      r.rem = df[NUM_W-1:0];
      r.q   = {s.q[FRAC-2:0], 1'b1};
    end else begin
      r.rem = sh[NUM_W-1:0];
      r.q   = {s.q[FRAC-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    init_d.rem  = num_i;
    init_d.den  = den_i;
    init_d.q    = '0;
    init_d.side = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FRAC-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= div_step(init_d);
      for (int g = 0; g < FRAC - 1; g++) begin
        stg_q[g+1] <= div_step(stg_q[g]);
      end
    end
  end

  assign vld_o  = vld_q[FRAC-1];
  assign quo_o  = stg_q[FRAC-1].q;
  assign side_o = stg_q[FRAC-1].side;

endmodule
